// ===== design/rau_pkg.sv =====
// Package: shared types and codes for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int unsigned FIELD_BITS = 64;

    typedef enum logic [2:0] {
        OP_SIMPLIFY = 3'd0,
        OP_COMPARE  = 3'd1,
        OP_ADD      = 3'd2,
        OP_SUB      = 3'd3,
        OP_MUL      = 3'd4,
        OP_DIV      = 3'd5
    } t_op;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [2:0]                   kind;
        logic signed [FIELD_BITS-1:0] a_num;
        logic signed [FIELD_BITS-1:0] a_den;
        logic signed [FIELD_BITS-1:0] b_num;
        logic signed [FIELD_BITS-1:0] b_den;
    } t_in_word;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] res_num;
        logic signed [FIELD_BITS-1:0] res_den;
        logic                         ok;
        logic [1:0]                   order;
    } t_out_word;

    // shared unit operations
    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_DIV = 2'd1,
        ALU_REM = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;
endpackage

// ===== design/rau_alu.sv =====
// Shared serial multiply / divide unit, one bit per cycle.
`timescale 1ns / 1ps
module rau_alu import rau_pkg::*; #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_alu_ctl     i_ctl,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_y
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    t_alu_op       r_op, n_op;
    logic [W-1:0]  r_acc, n_acc;   // product or remainder
    logic [W-1:0]  r_sh, n_sh;     // multiplier / dividend shifting out
    logic [W-1:0]  r_b, n_b;       // multiplicand / divisor magnitude
    logic          r_negq, n_negq, r_negr, n_negr;
    logic          r_done, n_done;
    logic [W:0]    trial;
    logic [W-1:0]  mag_a, mag_b, q_fix, r_fix;

    assign mag_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign trial = {r_acc, r_sh[W-1]} - {1'b0, r_b};
    assign q_fix = r_negq ? (~r_sh + 1'b1) : r_sh;
    assign r_fix = r_negr ? (~r_acc + 1'b1) : r_acc;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_b    = r_b;
        n_negq = r_negq;
        n_negr = r_negr;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_op   = i_ctl.op;
            n_acc  = '0;
            if (i_ctl.op == ALU_MUL) begin
                n_sh = i_a;
                n_b  = i_b;
            end else begin
                n_sh   = mag_a;
                n_b    = mag_b;
                n_negq = i_a[W-1] ^ i_b[W-1];
                n_negr = i_a[W-1];
            end
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                // low bits of product only: shift-add from the top
                n_acc = {r_acc[W-2:0], 1'b0} + (r_sh[W-1] ? r_b : '0);
                n_sh  = {r_sh[W-2:0], 1'b0};
            end else if (!trial[W]) begin
                n_acc = trial[W-1:0];
                n_sh  = {r_sh[W-2:0], 1'b1};
            end else begin
                n_acc = {r_acc[W-2:0], r_sh[W-1]};
                n_sh  = {r_sh[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op   <= n_op;
        r_acc  <= n_acc;
        r_sh   <= n_sh;
        r_b    <= n_b;
        r_negq <= n_negq;
        r_negr <= n_negr;
    end

    assign o_done = r_done;
    always_comb begin
        case (r_op)
            ALU_MUL: o_y = r_acc;
            ALU_DIV: o_y = q_fix;
            default: o_y = r_fix;
        endcase
    end
endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Top level: sequencer for rational arithmetic over a shared serial unit.
// Work: every multiply, divide or remainder runs serially on the shared unit;
// compare and multiply take 2 operations, add/sub 6 plus the gcd,
// simplify 2 plus the gcd loop (up to about 92 remainder steps at 64 bits).
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_in,
    output logic      busy,
    output logic      o_valid,
    output t_out_word o_out
);
    localparam int W = WORD_BITS;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_GSET = 11'b00000000010,
        S_GREM = 11'b00000000100,
        S_SDIV = 11'b00000001000,
        S_MUL1 = 11'b00000010000,
        S_MUL2 = 11'b00000100000,
        S_LCM  = 11'b00001000000,
        S_T1   = 11'b00010000000,
        S_T2   = 11'b00100000000,
        S_FIN  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state       r_st, n_st;
    logic [2:0]   r_kind;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [W-1:0] r_x, r_y;          // gcd pair
    logic [W-1:0] r_p, r_q, r_g;     // scratch results
    logic [2:0]   r_sub;             // sub-step within a state
    logic         r_wait;
    logic         r_valid;
    t_out_word    r_out;
    t_alu_ctl     alu_ctl;
    logic [W-1:0] alu_a, alu_b, alu_y;
    logic         alu_done;

    rau_alu #(.W(W)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (alu_ctl),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_done (alu_done),
        .o_y    (alu_y)
    );

    function automatic logic [FIELD_BITS-1:0] sx(input logic [W-1:0] v);
        return FIELD_BITS'($signed(v));
    endfunction

    function automatic logic s_gt(input logic [W-1:0] a, input logic [W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

    logic         go;
    logic         issue;
    logic [W-1:0] neg_an, neg_ad, neg_bn, neg_bd;
    assign go     = start && !busy;
    assign issue  = !r_wait && (r_st != S_IDLE) && (r_st != S_OUT) && (r_st != S_FIN)
                    && (r_st != S_GSET) && !(r_st == S_GREM && r_y == '0);
    assign neg_an = ~r_an + 1'b1;
    assign neg_ad = ~r_ad + 1'b1;
    assign neg_bn = ~r_bn + 1'b1;
    assign neg_bd = ~r_bd + 1'b1;

    // operand select for the shared unit
    always_comb begin
        alu_ctl.start = issue;
        alu_ctl.op    = ALU_MUL;
        alu_a = r_an;
        alu_b = r_bd;
        unique case (r_st)
            S_GREM: begin
                alu_ctl.op = ALU_REM;
                alu_a = r_x;
                alu_b = r_y;
            end
            S_SDIV: begin
                alu_ctl.op = ALU_DIV;
                alu_a = (r_sub == 3'd0) ? r_an : r_ad;
                alu_b = r_g;
            end
            S_MUL1: begin
                alu_a = (r_kind == OP_DIV) ? r_an : r_an;
                alu_b = (r_kind == OP_MUL) ? r_bn : r_bd;
            end
            S_MUL2: begin
                alu_a = (r_kind == OP_COMPARE) ? r_bn : r_ad;
                alu_b = (r_kind == OP_COMPARE) ? r_ad :
                        (r_kind == OP_DIV) ? r_bn : r_bd;
            end
            S_LCM: begin
                alu_ctl.op = ALU_DIV;
                alu_a = r_q;
                alu_b = r_g;
            end
            S_T1: begin
                alu_ctl.op = (r_sub == 3'd0) ? ALU_MUL : ALU_DIV;
                alu_a = (r_sub == 3'd0) ? r_an : r_p;
                alu_b = (r_sub == 3'd0) ? r_g : r_ad;
            end
            S_T2: begin
                alu_ctl.op = (r_sub == 3'd0) ? ALU_MUL : ALU_DIV;
                alu_a = (r_sub == 3'd0) ? r_bn : r_q;
                alu_b = (r_sub == 3'd0) ? r_g : r_bd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_wait  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (issue) r_wait <= 1'b1;
            if (alu_done) r_wait <= 1'b0;
            unique case (r_st)
                S_IDLE: if (go) begin
                    r_kind <= i_in.kind;
                    r_an   <= i_in.a_num[W-1:0];
                    r_ad   <= i_in.a_den[W-1:0];
                    r_bn   <= i_in.b_num[W-1:0];
                    r_bd   <= i_in.b_den[W-1:0];
                    r_sub  <= '0;
                    r_out  <= '0;
                    r_st   <= S_GSET;
                end
                S_GSET: begin
                    // validity checks, sign setup for compare, gcd setup
                    if (r_kind == OP_SIMPLIFY) begin
                        if (r_ad == '0) begin
                            r_out.res_num <= sx(r_an);
                            r_out.res_den <= sx(r_ad);
                            r_st <= S_OUT;
                        end else begin
                            r_x  <= s_gt(r_ad, r_an) ? r_ad : r_an;
                            r_y  <= s_gt(r_ad, r_an) ? r_an : r_ad;
                            r_st <= S_GREM;
                        end
                    end else if (r_kind > 3'(OP_DIV) || r_ad == '0 || r_bd == '0) begin
                        r_st <= S_OUT;
                    end else if (r_kind == OP_COMPARE) begin
                        if (r_ad[W-1]) begin
                            r_an <= neg_an;
                            r_ad <= neg_ad;
                        end
                        if (r_bd[W-1]) begin
                            r_bn <= neg_bn;
                            r_bd <= neg_bd;
                        end
                        r_st <= S_MUL1;
                    end else if (r_kind == OP_ADD || r_kind == OP_SUB) begin
                        r_x  <= s_gt(r_bd, r_ad) ? r_bd : r_ad;
                        r_y  <= s_gt(r_bd, r_ad) ? r_ad : r_bd;
                        r_st <= S_GREM;
                    end else begin
                        r_st <= S_MUL1;
                    end
                end
                S_GREM: begin
                    if (r_y == '0 && !r_wait) begin
                        r_g <= r_x;
                        if (r_kind == OP_SIMPLIFY) begin
                            r_st <= (r_x == '0) ? S_FIN : S_SDIV;
                        end else begin
                            r_st <= S_MUL2;
                        end
                    end else if (alu_done) begin
                        r_x <= r_y;
                        r_y <= alu_y;
                    end
                end
                S_SDIV: if (alu_done) begin
                    if (r_sub == 3'd0) begin
                        r_an  <= alu_y;
                        r_sub <= 3'd1;
                    end else begin
                        r_ad  <= alu_y;
                        r_sub <= 3'd0;
                        r_st  <= S_FIN;
                    end
                end
                S_MUL1: if (alu_done) begin
                    r_p  <= alu_y;
                    r_st <= S_MUL2;
                end
                S_MUL2: if (alu_done) begin
                    r_q <= alu_y;
                    if (r_kind == OP_ADD || r_kind == OP_SUB) begin
                        r_st <= (r_g == '0) ? S_T1 : S_LCM;
                        if (r_g == '0) r_g <= '0;
                    end else begin
                        r_st <= S_FIN;
                    end
                end
                S_LCM: if (alu_done) begin
                    r_g  <= alu_y;   // r_g now holds the lcm
                    r_st <= S_T1;
                end
                S_T1: if (alu_done) begin
                    r_p <= alu_y;
                    if (r_sub == 3'd0) r_sub <= 3'd1;
                    else begin
                        r_sub <= 3'd0;
                        r_st  <= S_T2;
                    end
                end
                S_T2: if (alu_done) begin
                    r_q <= alu_y;
                    if (r_sub == 3'd0) r_sub <= 3'd1;
                    else begin
                        r_sub <= 3'd0;
                        r_st  <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out.ok <= 1'b1;
                    case (r_kind)
                        OP_SIMPLIFY: begin
                            r_out.res_num <= sx(r_ad[W-1] ? neg_an : r_an);
                            r_out.res_den <= sx(r_ad[W-1] ? neg_ad : r_ad);
                        end
                        OP_COMPARE: begin
                            r_out.order <= ($signed(r_p) < $signed(r_q)) ? ORD_LESS :
                                           ($signed(r_p) > $signed(r_q)) ? ORD_GREATER :
                                           ORD_EQUAL;
                        end
                        OP_ADD: begin
                            r_out.res_num <= sx(r_p + r_q);
                            r_out.res_den <= sx(r_g);
                        end
                        OP_SUB: begin
                            r_out.res_num <= sx(r_p - r_q);
                            r_out.res_den <= sx(r_g);
                        end
                        default: begin
                            r_out.res_num <= sx(r_p);
                            r_out.res_den <= sx(r_q);
                        end
                    endcase
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_st != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("state not one-hot");
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double strobe");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> busy) else $error("accept without busy");
    a_nowait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !r_wait) else $error("unit busy in idle");
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the rational arithmetic unit: directed and random words, self-checking.
`timescale 1ns / 1ps
module tb;
    import rau_pkg::*;

    localparam int HOLD_LIMIT = 200000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_word  i_in;
    logic      busy;
    logic      o_valid;
    t_out_word o_out;

    t_out_word expected_q[$];
    int        n_errors;
    int        n_sent;
    int        n_checked;
    int        idle_cycles;
    bit        gaps_on;

    rational_arithmetic_unit #(.WORD_BITS(64)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    // wrapping 64-bit helpers, truncating division
    function automatic logic [63:0] mag(logic [63:0] a);
        return a[63] ? -a : a;
    endfunction

    function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        q = mag(a) / mag(b);
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] srem(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = mag(a) % mag(b);
        return a[63] ? -r : r;
    endfunction

    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        if ($signed(b) > $signed(a)) begin
            t = a;
            a = b;
            b = t;
        end
        while (b != 0) begin
            t = srem(a, b);
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_out_word rational_result(t_in_word w);
        t_out_word   r;
        logic [63:0] an, ad, bn, bd, g, den, t1, t2, l, rr;
        r  = '0;
        an = w.a_num;
        ad = w.a_den;
        bn = w.b_num;
        bd = w.b_den;
        if (w.kind == OP_SIMPLIFY) begin
            if (ad == 0) begin
                r.res_num = an;
                r.res_den = ad;
            end else begin
                g = euclid_gcd(an, ad);
                r.ok = 1'b1;
                if (g != 0) begin
                    an = sdiv(an, g);
                    ad = sdiv(ad, g);
                end
                if (ad[63]) begin
                    an = -an;
                    ad = -ad;
                end
                r.res_num = an;
                r.res_den = ad;
            end
        end else if (w.kind <= OP_DIV && ad != 0 && bd != 0) begin
            r.ok = 1'b1;
            case (w.kind)
                OP_COMPARE: begin
                    if (ad[63]) begin
                        an = -an;
                        ad = -ad;
                    end
                    if (bd[63]) begin
                        bn = -bn;
                        bd = -bd;
                    end
                    l  = an * bd;
                    rr = bn * ad;
                    r.order = ($signed(l) < $signed(rr)) ? ORD_LESS :
                              ($signed(l) > $signed(rr)) ? ORD_GREATER : ORD_EQUAL;
                end
                OP_ADD, OP_SUB: begin
                    g   = euclid_gcd(ad, bd);
                    den = (g != 0) ? sdiv(ad * bd, g) : 64'd0;
                    t1  = sdiv(an * den, ad);
                    t2  = sdiv(bn * den, bd);
                    r.res_num = (w.kind == OP_ADD) ? t1 + t2 : t1 - t2;
                    r.res_den = den;
                end
                OP_MUL: begin
                    r.res_num = an * bn;
                    r.res_den = ad * bd;
                end
                default: begin
                    r.res_num = an * bd;
                    r.res_den = ad * bn;
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %h, expected %h", what, got, want);
    endtask

    // checker: results cannot be held off, so sample every edge
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", o_out.res_num, 64'd0);
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (o_out.res_num !== want.res_num)
                    report_mismatch("res_num", o_out.res_num, want.res_num);
                if (o_out.res_den !== want.res_den)
                    report_mismatch("res_den", o_out.res_den, want.res_den);
                if (o_out.ok !== want.ok)
                    report_mismatch("ok", o_out.ok, want.ok);
                if (o_out.order !== want.order)
                    report_mismatch("order", o_out.order, want.order);
            end
        end
    end

    // watchdog: cycles with nothing accepted and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HOLD_LIMIT) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    // start stays high after an accept; busy blocks a second accept until the
    // next word is on i_in
    task automatic send_word(t_in_word w);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(rational_result(w));
        n_sent++;
    endtask

    task automatic send_fields(logic [2:0] k, logic [63:0] an, logic [63:0] ad,
                               logic [63:0] bn, logic [63:0] bd);
        t_in_word w;
        w.kind  = k;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
        send_word(w);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_field();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: return v;
            1: return 64'($signed(v[7:0]));
            2: return 64'($signed(v[19:0]));
            3: return 64'($signed(v[35:0]));
            4: return MIN64 + v[3:0];
            default: return 64'($signed(v[11:0])) * 64'($signed(v[23:12]));
        endcase
    endfunction

    task automatic test_directed_simplify();
        send_fields(OP_SIMPLIFY, 64'd6, 64'd8, 0, 0);
        send_fields(OP_SIMPLIFY, -64'sd6, -64'sd9, 0, 0);
        send_fields(OP_SIMPLIFY, 64'd5, 64'd0, 0, 0);
        send_fields(OP_SIMPLIFY, 64'd0, -64'sd7, 0, 0);
        send_fields(OP_SIMPLIFY, MIN64, -64'sd1, 0, 0);
        send_fields(OP_SIMPLIFY, 64'h7fff_ffff_ffff_ffff, MIN64, 64'hffff_ffff_ffff_ffff, 1);
        send_fields(OP_SIMPLIFY, MIN64, MIN64, 0, 0);
    endtask

    task automatic test_directed_compare();
        send_fields(OP_COMPARE, 1, 2, 1, 3);
        send_fields(OP_COMPARE, 1, 3, 1, 2);
        send_fields(OP_COMPARE, 2, -4, -1, 2);
        send_fields(OP_COMPARE, 1, 0, 1, 2);
        send_fields(OP_COMPARE, MIN64, 1, 64'h7fff_ffff_ffff_ffff, -64'sd1);
    endtask

    task automatic test_directed_arith();
        send_fields(OP_ADD, 1, 6, 1, 4);
        send_fields(OP_SUB, 1, 6, 1, 4);
        send_fields(OP_ADD, 1, 64'h1_0000_0000, 1, 64'h1_0000_0001);
        send_fields(OP_SUB, 3, -64'sd5, 2, 0);
        send_fields(OP_MUL, MIN64, -64'sd1, 64'h7fff_ffff_ffff_ffff, MIN64);
        send_fields(OP_MUL, 3, 4, 5, 0);
        send_fields(OP_DIV, 3, 4, 5, 7);
        send_fields(OP_DIV, MIN64, -64'sd1, 0, 64'hffff_ffff_ffff_ffff);
        send_fields(3'd6, 1, 2, 3, 4);
        send_fields(3'd7, -64'sd1, -64'sd1, -64'sd1, -64'sd1);
    endtask

    task automatic test_random(int count);
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            w.kind  = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
            w.a_num = rand_field();
            w.a_den = ($urandom_range(0, 12) == 0) ? 64'd0 : rand_field();
            w.b_num = rand_field();
            w.b_den = ($urandom_range(0, 12) == 0) ? 64'd0 : rand_field();
            send_word(w);
            if (i == count / 2) drain();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        n_errors    = 0;
        n_sent      = 0;
        n_checked   = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_simplify();
        test_directed_compare();
        test_directed_arith();
        drain();
        test_random(80);
        gaps_on = 1'b0;
        test_random(20);

        drain();
        repeat (2000) @(posedge i_clk);
        $display("ran %0d words over all operations, codes and edge values; %0d checked",
                 n_sent, n_checked);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d words outstanding", n_errors, expected_q.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/rau_pkg.sv
design/rau_alu.sv
design/rational_arithmetic_unit.sv
tb/sv/tb.sv
